/* src/abffc_pkg.sv */
package abffc_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_SEL_W = 5;
  localparam int COUNT_W = 13;
  localparam int IDX_W = 12;
  localparam int OP_W = 3;

  localparam logic [COUNT_W-1:0] BIT_COUNT_RST = 13'd4096;

  localparam logic [OP_W-1:0] OP_TEST       = 3'd0;
  localparam logic [OP_W-1:0] OP_SET        = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND_RANGE = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND_ANY   = 3'd4;

  typedef struct packed {
    logic clr_write;
    logic load;
    logic rd_en;
    logic advance;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic done;
  } dp_stat_t;

  typedef struct packed {
    logic [IDX_W-1:0] found_index;
    logic             found;
    logic             status;
    logic             bit_value;
  } result_t;

endpackage

/* src/abffc_dp.sv */
module abffc_dp #(
  parameter int BITMAP_BITS = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  abffc_pkg::dp_cmd_t               cmd,
  output abffc_pkg::dp_stat_t              stat,
  input  logic                             cfg_we,
  input  logic [abffc_pkg::COUNT_W-1:0]    cfg_data,
  input  logic [abffc_pkg::OP_W-1:0]       in_opcode,
  input  logic [abffc_pkg::IDX_W-1:0]      in_bit_addr,
  input  logic [abffc_pkg::IDX_W-1:0]      in_range_start,
  input  logic [abffc_pkg::IDX_W-1:0]      in_range_end,
  output abffc_pkg::result_t               result
);

  localparam int WB = abffc_pkg::WORD_BITS;
  localparam int SW = abffc_pkg::BIT_SEL_W;
  localparam int WORD_COUNT = (BITMAP_BITS + WB - 1) / WB;
  localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int CNT_W0 = $clog2(BITMAP_BITS + 1);
  localparam int CW = (CNT_W0 > abffc_pkg::COUNT_W) ? CNT_W0 : abffc_pkg::COUNT_W;

  logic [WB-1:0] mem [WORD_COUNT];
  logic [WB-1:0] rd_data;
  logic [WB-1:0] wr_word;
  logic          wr_en;
  logic [AW-1:0] clr_ptr;

  logic [abffc_pkg::COUNT_W-1:0] bit_count;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] n_m1;
  logic [CW-1:0] ext_idx;
  logic [CW-1:0] ext_re;
  logic [CW-1:0] first_next;
  logic [CW-1:0] last_next;
  logic          invalid_next;
  logic          skip_next;
  logic [AW-1:0] ptr_next;

  logic [abffc_pkg::OP_W-1:0] op;
  logic          invalid;
  logic          skip;
  logic          first_flag;
  logic [AW-1:0] ptr;
  logic [AW-1:0] last_ptr;
  logic [SW-1:0] lo_bit;
  logic [SW-1:0] hi_bit;
  logic [SW-1:0] bit_sel;

  logic          is_find;
  logic          is_write;
  logic          at_last;
  logic [SW-1:0] lo_eff;
  logic [SW-1:0] hi_eff;
  logic [WB-1:0] mask;
  logic [WB-1:0] cand;
  logic          hit;
  logic [SW-1:0] pos;
  logic [CW-1:0] full_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= abffc_pkg::BIT_COUNT_RST;
      clr_ptr <= '0;
    end else begin
      if (cfg_we) begin
        bit_count <= cfg_data;
      end
      if (cmd.clr_write) begin
        clr_ptr <= clr_ptr + 1'b1;
      end
    end
  end

  assign stat.clr_last = (clr_ptr == AW'(WORD_COUNT - 1));

  always_comb begin
    n_eff = (CW'(bit_count) > CW'(BITMAP_BITS)) ? CW'(BITMAP_BITS) : CW'(bit_count);
    n_m1 = n_eff - CW'(1);
    ext_idx = CW'(in_bit_addr);
    ext_re = CW'(in_range_end);
    invalid_next = 1'b0;
    first_next = '0;
    last_next = '0;
    skip_next = 1'b1;
    ptr_next = AW'(ext_idx >> SW);
    case (in_opcode)
      abffc_pkg::OP_TEST, abffc_pkg::OP_SET, abffc_pkg::OP_CLEAR: begin
        invalid_next = (ext_idx >= n_eff);
        skip_next = invalid_next;
      end
      abffc_pkg::OP_FIND_RANGE: begin
        first_next = CW'(in_range_start);
        last_next = (ext_re > n_m1) ? n_m1 : ext_re;
        skip_next = (n_eff == '0) || (first_next > last_next);
        ptr_next = AW'(first_next >> SW);
      end
      abffc_pkg::OP_FIND_ANY: begin
        last_next = n_m1;
        skip_next = (n_eff == '0);
        ptr_next = '0;
      end
      default: begin
        skip_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_opcode;
      invalid <= invalid_next;
      skip <= skip_next;
      ptr <= ptr_next;
      last_ptr <= AW'(last_next >> SW);
      lo_bit <= first_next[SW-1:0];
      hi_bit <= last_next[SW-1:0];
      bit_sel <= in_bit_addr[SW-1:0];
      first_flag <= 1'b1;
    end else if (cmd.advance) begin
      ptr <= ptr + 1'b1;
      first_flag <= 1'b0;
    end
  end

  always_comb begin
    is_find = (op == abffc_pkg::OP_FIND_RANGE) || (op == abffc_pkg::OP_FIND_ANY);
    is_write = (op == abffc_pkg::OP_SET) || (op == abffc_pkg::OP_CLEAR);
    at_last = (ptr == last_ptr);
    lo_eff = first_flag ? lo_bit : '0;
    hi_eff = at_last ? hi_bit : SW'(WB - 1);
    mask = ({WB{1'b1}} << lo_eff) & ({WB{1'b1}} >> (SW'(WB - 1) - hi_eff));
    cand = ~rd_data & mask;
    hit = 1'b0;
    pos = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit = 1'b1;
        pos = SW'(i);
      end
    end
    full_idx = (CW'(ptr) << SW) | CW'(pos);
    wr_word = rd_data;
    wr_word[bit_sel] = (op == abffc_pkg::OP_SET);
    wr_en = cmd.commit && is_write && !skip;
  end

  assign stat.done = !is_find || skip || hit || at_last;

  always_ff @(posedge clk) begin
    if (cmd.clr_write) begin
      mem[clr_ptr] <= '0;
    end else if (wr_en) begin
      mem[ptr] <= wr_word;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.bit_value <= (op == abffc_pkg::OP_TEST) && !skip && rd_data[bit_sel];
      result.status <= invalid;
      result.found <= is_find && !skip && hit;
      result.found_index <= (is_find && !skip && hit) ? abffc_pkg::IDX_W'(full_idx) : '0;
    end
  end

endmodule

/* src/abffc_ctrl.sv */
module abffc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output abffc_pkg::dp_cmd_t   cmd,
  input  abffc_pkg::dp_stat_t  stat
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_EVAL  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (!stat.done) begin
          cmd.advance = 1'b1;
          state_next = ST_READ;
        end else if (!out_valid || m_tready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= cmd.commit || (out_valid && !m_tready);
    end
  end

  assign m_tvalid = out_valid;

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || m_tready))
    else $error("result committed over an untaken word");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready)
    else $error("input accepted during clearing pass");
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (state == ST_IDLE) && m_tvalid)
    else $error("commit did not return to idle with a result");
  a_read_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |=> (state == ST_EVAL))
    else $error("read not followed by evaluation");
`endif

endmodule

/* src/allocation_bitmap_find_first_clear.sv */
// Allocation bitmap with find-first-clear over BITMAP_BITS bits held in 32-bit words.
// Requests arrive on the s_ stream: s_tuser carries the opcode (test, set, clear,
// find clear in range, find clear anywhere) and s_tdata the bit index and range.
// Each accepted word gives exactly one result word on the m_ stream.
// The bit count in use is written on the cfg channel, which is always ready;
// write it only while no request is in flight.
// A test, set or clear moves through idle, where the word is accepted, a read state
// for the word and an evaluate state; m_tvalid rises as the controller returns to
// idle, and the next word can be accepted in the same cycle that it rises.
// A search reads one word at a time through the single read port, alternating the
// read and evaluate states per word until a clear bit or the last word is reached.
// After reset the memory is cleared one word a cycle, and s_tready stays low until
// that pass is done; bit count resets to 4096.
// The result sits in an output register; while the receiver stalls, the next
// request is still accepted and processed up to its result, which then waits.
module allocation_bitmap_find_first_clear #(
  parameter int BITMAP_BITS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // bit address, range start, range end, zero pad
  input  logic [2:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // bit_value, status, found, found_index, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

  abffc_pkg::dp_cmd_t  cmd;
  abffc_pkg::dp_stat_t stat;
  abffc_pkg::result_t  result;

  assign cfg_ready = 1'b1;

  abffc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  abffc_dp #(
    .BITMAP_BITS (BITMAP_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .in_opcode      (s_tuser),
    .in_bit_addr    (s_tdata[11:0]),
    .in_range_start (s_tdata[23:12]),
    .in_range_end   (s_tdata[35:24]),
    .result         (result)
  );

  assign m_tdata = {1'b0, result};

endmodule
